[rtl/pida_pkg.sv]
// Package for the positional insert/delete array: beat types, codes and defaults.
package pida_pkg;

    // Default number of array slots
    localparam int CAPACITY_DEF = 16;

    // Command modes
    localparam logic [1:0] MODE_DISPLAY = 2'd0;
    localparam logic [1:0] MODE_INSERT  = 2'd1;
    localparam logic [1:0] MODE_DELETE  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_BADIDX = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    // Command beat
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic [4:0]         position;
    } cmd_item_t;

    // Result beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [4:0]         entry_count;
        logic               last;
    } rsp_item_t;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] value;
        logic [4:0]         position;
    } cell_cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } ctrl_state_t;

endpackage

[rtl/pida_cell.sv]
// One slot of the array: holds an entry and trades it with its neighbors.
module pida_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                  clk,
    input  pida_pkg::cell_cmd_t   cmd,
    input  logic [CNT_W-1:0]      last_idx,
    input  logic signed [31:0]    left,
    input  logic signed [31:0]    right,
    input  logic signed [31:0]    head,
    output logic signed [31:0]    entry
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    // Select the new content from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            pida_pkg::OP_HOLD:
            begin
                entry_next = entry_reg;
            end
            pida_pkg::OP_INSERT:
            begin
                // shift up above the insert point, take the value at it
                if (IDX > int'(cmd.position))
                    entry_next = left;
                else if (IDX == int'(cmd.position))
                    entry_next = cmd.value;
            end
            pida_pkg::OP_DELETE:
            begin
                // shift down from the delete point; top slot becomes don't-care
                if (IDX >= int'(cmd.position))
                    entry_next = right;
            end
            pida_pkg::OP_ROTATE:
            begin
                // rotate valid entries toward slot zero, head wraps to the top
                if (IDX < int'(last_idx))
                    entry_next = right;
                else if (IDX == int'(last_idx))
                    entry_next = head;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[rtl/pida_ctrl.sv]
// Controller: command decode, entry count, display sequencing and result register.
module pida_ctrl #(
    parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    output logic                                   cmd_stall,
    input  pida_pkg::cmd_item_t                    cmd,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output pida_pkg::rsp_item_t                    rsp,
    input  logic signed [31:0]                     head,
    output pida_pkg::cell_cmd_t                    cell_cmd,
    output logic [$clog2(CAPACITY+1)-1:0]          last_idx
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    pida_pkg::ctrl_state_t state_reg;
    pida_pkg::ctrl_state_t state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pida_pkg::rsp_item_t   out_reg;
    pida_pkg::rsp_item_t   out_next;
    logic                  out_load;
    logic                  out_free;
    logic                  accept;
    logic                  disp_last;

    // Handshake
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != pida_pkg::ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign last_idx  = count_reg - CNT_W'(1);
    assign disp_last = (CNT_W'(idx_reg) == last_idx);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pida_pkg::ST_IDLE:
            begin
                if (accept && cmd.mode == pida_pkg::MODE_DISPLAY && count_reg != '0)
                    state_next = pida_pkg::ST_DISP;
            end
            pida_pkg::ST_DISP:
            begin
                if (out_free && disp_last)
                    state_next = pida_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        count_next        = count_reg;
        idx_next          = idx_reg;
        out_load          = 1'b0;
        out_next          = out_reg;
        cell_cmd.op       = pida_pkg::OP_HOLD;
        cell_cmd.value    = cmd.value;
        cell_cmd.position = cmd.position;
        unique case (state_reg)
            pida_pkg::ST_IDLE:
            begin
                out_next.element = '0;
                out_next.last    = 1'b1;
                if (accept)
                begin
                    unique case (cmd.mode)
                        pida_pkg::MODE_DISPLAY:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                out_load           = 1'b1;
                                out_next.status    = pida_pkg::STAT_EMPTY;
                                out_next.entry_count = 5'(count_reg);
                            end
                        end
                        pida_pkg::MODE_INSERT:
                        begin
                            out_load = 1'b1;
                            if (int'(count_reg) >= CAPACITY)
                                out_next.status = pida_pkg::STAT_FULL;
                            else if (int'(cmd.position) > int'(count_reg))
                                out_next.status = pida_pkg::STAT_BADIDX;
                            else
                            begin
                                out_next.status = pida_pkg::STAT_OK;
                                cell_cmd.op     = pida_pkg::OP_INSERT;
                                count_next      = count_reg + CNT_W'(1);
                            end
                            out_next.entry_count = 5'(count_next);
                        end
                        pida_pkg::MODE_DELETE:
                        begin
                            out_load = 1'b1;
                            if (count_reg == '0)
                                out_next.status = pida_pkg::STAT_EMPTY;
                            else if (int'(cmd.position) >= int'(count_reg))
                                out_next.status = pida_pkg::STAT_BADIDX;
                            else
                            begin
                                out_next.status = pida_pkg::STAT_OK;
                                cell_cmd.op     = pida_pkg::OP_DELETE;
                                count_next      = count_reg - CNT_W'(1);
                            end
                            out_next.entry_count = 5'(count_next);
                        end
                        default:
                        begin
                            // unused mode: consumed, no result
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            pida_pkg::ST_DISP:
            begin
                // one entry per beat from slot zero, then rotate the chain
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.status      = pida_pkg::STAT_OK;
                    out_next.element     = head;
                    out_next.entry_count = 5'(count_reg);
                    out_next.last        = disp_last;
                    cell_cmd.op          = pida_pkg::OP_ROTATE;
                    idx_next             = idx_reg + IDX_W'(1);
                end
            end
        endcase
    end

    // Result valid
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pida_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[rtl/positional_insert_delete_array.sv]
// Top level of the positional insert/delete array: controller and chain of slots.
// Ordered array of up to CAPACITY signed 32-bit entries with insert, delete and display
// at a position. On insert and delete every slot loads from its neighbor at once, and the
// status beat (full, bad index, empty or ok) is ready the next cycle. Display rotates the
// valid entries through slot zero, one result beat per cycle while the result is not stalled,
// and takes no new command until its last beat is loaded; with no entries it gives a single
// empty status beat instead. A command is accepted whenever the block is idle and the
// result register is free or being emptied in that cycle. Mode 3 is consumed without a
// result. entry_count reports the count after the command, in five bits.
module positional_insert_delete_array #(
    parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  pida_pkg::cmd_item_t  cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output pida_pkg::rsp_item_t  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    pida_pkg::cell_cmd_t  cell_cmd;
    logic [CNT_W-1:0]     last_idx;
    logic signed [31:0]   entry_w [CAPACITY];

    // Command decode and sequencing
    pida_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head      (entry_w[0]),
        .cell_cmd  (cell_cmd),
        .last_idx  (last_idx)
    );

    // Chain of slots, slot zero at the bottom
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;

        if (i == 0)
        begin : g_lo
            assign left_w = '0;
        end
        else
        begin : g_lo
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_hi
            assign right_w = '0;
        end
        else
        begin : g_hi
            assign right_w = entry_w[i+1];
        end

        pida_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .cmd      (cell_cmd),
            .last_idx (last_idx),
            .left     (left_w),
            .right    (right_w),
            .head     (entry_w[0]),
            .entry    (entry_w[i])
        );
    end

endmodule
